/* sv/rfd_pkg.sv */
`default_nettype none

package rfd_pkg;

  // Header layout, little endian.
  localparam int unsigned HdrBytes = 12;
  localparam int unsigned HdrIdxW  = $clog2(HdrBytes);
  localparam int unsigned CntW     = 32;

  localparam int unsigned MagicAt  = 0;
  localparam int unsigned TypeAt   = 2;
  localparam int unsigned CtlLenAt = 4;
  localparam int unsigned DataLenAt = 6;
  localparam int unsigned OffsetAt = 10;
  localparam int unsigned FlagsAt  = 11;

  // Configuration register indexes.
  localparam logic [0:0] CfgMagic     = 1'b0;
  localparam logic [0:0] CfgMaxDataLen = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTROL = 2'd1,
    PH_DATA    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_HEADER  = 2'd0,
    REG_CONTROL = 2'd1,
    REG_DATA    = 2'd2,
    REG_NONE    = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_OFFSET = 2'd2,
    ERR_DLEN   = 2'd3
  } err_e;

endpackage

`default_nettype wire

/* sv/rpc_frame_deframer.sv */
// Length-prefixed frame deframer.
// Input channel (in_valid_i / in_ready_o) carries one stream byte per beat,
// together with an abort bit. Output channel (out_valid_o / out_ready_i)
// carries exactly one result beat per input beat: the byte passed through,
// its region (header, control, data or not consumed), a frame-end flag, the
// sticky error code, and the header fields, which are nonzero only on the
// beat that ends a frame.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i (0 magic word,
// 1 maximum data length) and cfg_wdata_i. Write it only while idle.
// A beat accepted at one edge shows up on the output after that edge.
// Throughput is one beat per cycle while the receiver keeps up; the whole
// decision for a byte is a counter increment, 32-bit compares and the
// header checks, all between the state registers and the output register.
// Reset clears the phase, the byte count, the error and the output valid,
// and loads the magic word with 0 and the maximum data length with all ones.
// The header bytes themselves are not reset; each is written before use.
// When the receiver stalls, the output register holds its beat and input
// ready drops only while that beat is still unread, so a new byte is taken
// in the same cycle the pending result leaves.
`default_nettype none

module rpc_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        abort_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       byte_out_o,
  output logic [1:0]       region_o,
  output logic             frame_end_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      frame_type_o,
  output logic [15:0]      control_len_o,
  output logic [31:0]      data_len_o,
  output logic [7:0]       msg_offset_o,
  output logic [7:0]       flags_o
);

  // Configuration registers.
  logic [15:0] magic_q;
  logic [31:0] max_dlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= '0;
      max_dlen_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfd_pkg::CfgMagic:      magic_q    <= cfg_wdata_i[15:0];
        rfd_pkg::CfgMaxDataLen: max_dlen_q <= cfg_wdata_i;
        default:                magic_q    <= magic_q;
      endcase
    end
  end

  // Frame state.
  rfd_pkg::phase_e phase_q, phase_d;
  rfd_pkg::err_e   err_q, err_d;
  logic [rfd_pkg::CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0] hdr_q [rfd_pkg::HdrBytes];
  logic       hdr_we;

  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Header fields as seen from the stored bytes.
  logic [15:0] hdr_magic, hdr_type, hdr_ctl_len;
  logic [31:0] hdr_dlen;
  logic [7:0]  hdr_offset, hdr_flags;

  assign hdr_magic   = {hdr_q[rfd_pkg::MagicAt+1], hdr_q[rfd_pkg::MagicAt]};
  assign hdr_type    = {hdr_q[rfd_pkg::TypeAt+1], hdr_q[rfd_pkg::TypeAt]};
  assign hdr_ctl_len = {hdr_q[rfd_pkg::CtlLenAt+1], hdr_q[rfd_pkg::CtlLenAt]};
  assign hdr_dlen    = {hdr_q[rfd_pkg::DataLenAt+3], hdr_q[rfd_pkg::DataLenAt+2],
                        hdr_q[rfd_pkg::DataLenAt+1], hdr_q[rfd_pkg::DataLenAt]};
  assign hdr_offset  = hdr_q[rfd_pkg::OffsetAt];
  // The flags byte is the last header byte, so in the header phase it is
  // still on the input when an empty frame ends.
  assign hdr_flags   = (phase_q == rfd_pkg::PH_CONTROL || phase_q == rfd_pkg::PH_DATA)
                       ? hdr_q[rfd_pkg::FlagsAt] : byte_in_i;

  // Header check, in priority order.
  rfd_pkg::err_e chk;
  always_comb begin
    priority if (hdr_magic != magic_q) begin
      chk = rfd_pkg::ERR_MAGIC;
    end else if (hdr_offset < 8'(rfd_pkg::HdrBytes)) begin
      chk = rfd_pkg::ERR_OFFSET;
    end else if (hdr_dlen > max_dlen_q) begin
      chk = rfd_pkg::ERR_DLEN;
    end else begin
      chk = rfd_pkg::ERR_NONE;
    end
  end

  assign cnt_inc = cnt_q + 32'd1;

  rfd_pkg::region_e region;
  logic             fend;

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    region  = rfd_pkg::REG_NONE;
    fend    = 1'b0;
    hdr_we  = 1'b0;
    if (abort_i) begin
      err_d   = rfd_pkg::ERR_NONE;
      phase_d = rfd_pkg::PH_HEADER;
      cnt_d   = '0;
    end else if (err_q == rfd_pkg::ERR_NONE) begin
      unique case (phase_q)
        rfd_pkg::PH_CONTROL: begin
          region = rfd_pkg::REG_CONTROL;
          if (cnt_inc >= {16'd0, hdr_ctl_len}) begin
            cnt_d = '0;
            if (hdr_dlen == 32'd0) begin
              fend    = 1'b1;
              phase_d = rfd_pkg::PH_HEADER;
            end else begin
              phase_d = rfd_pkg::PH_DATA;
            end
          end else begin
            cnt_d = cnt_inc;
          end
        end
        rfd_pkg::PH_DATA: begin
          region = rfd_pkg::REG_DATA;
          if (cnt_inc >= hdr_dlen) begin
            cnt_d   = '0;
            fend    = 1'b1;
            phase_d = rfd_pkg::PH_HEADER;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: begin
          phase_d = rfd_pkg::PH_HEADER;
          region  = rfd_pkg::REG_HEADER;
          hdr_we  = (cnt_q < 32'(rfd_pkg::HdrBytes));
          if (cnt_inc >= 32'(rfd_pkg::HdrBytes)) begin
            cnt_d = '0;
            if (chk != rfd_pkg::ERR_NONE) begin
              err_d = chk;
            end else if (hdr_ctl_len != 16'd0) begin
              phase_d = rfd_pkg::PH_CONTROL;
            end else if (hdr_dlen != 32'd0) begin
              phase_d = rfd_pkg::PH_DATA;
            end else begin
              fend = 1'b1;
            end
          end else begin
            cnt_d = cnt_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rfd_pkg::PH_HEADER;
      err_q   <= rfd_pkg::ERR_NONE;
      cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && hdr_we) begin
      hdr_q[cnt_q[rfd_pkg::HdrIdxW-1:0]] <= byte_in_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire || (out_valid_q && !out_ready_i);
    end
  end

  logic [7:0]  byte_q, offset_q, flags_q;
  logic [1:0]  region_q, errc_q;
  logic        fend_q;
  logic [15:0] type_q, ctl_q;
  logic [31:0] dlen_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q   <= byte_in_i;
      region_q <= region;
      fend_q   <= fend;
      errc_q   <= err_d;
      type_q   <= fend ? hdr_type    : 16'd0;
      ctl_q    <= fend ? hdr_ctl_len : 16'd0;
      dlen_q   <= fend ? hdr_dlen    : 32'd0;
      offset_q <= fend ? hdr_offset  : 8'd0;
      flags_q  <= fend ? hdr_flags   : 8'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = byte_q;
  assign region_o      = region_q;
  assign frame_end_o   = fend_q;
  assign error_code_o  = errc_q;
  assign frame_type_o  = type_q;
  assign control_len_o = ctl_q;
  assign data_len_o    = dlen_q;
  assign msg_offset_o  = offset_q;
  assign flags_o       = flags_q;

endmodule

`default_nettype wire

/* sv/rfd_checker.sv */
`default_nettype none

module rfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        abort_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  byte_out_o,
  input wire logic [1:0]  region_o,
  input wire logic        frame_end_o,
  input wire logic [1:0]  error_code_o,
  input wire logic [15:0] frame_type_o,
  input wire logic [31:0] data_len_o
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_out_o) && $stable(region_o))
    else $error("stalled result beat changed");

  // Every accepted byte yields a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted byte gave no result");

  // An abort beat is not consumed and clears the error.
  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && abort_i |=>
      region_o == rfd_pkg::REG_NONE && error_code_o == rfd_pkg::ERR_NONE)
    else $error("abort beat not reported as unconsumed");

  // A frame only ends on a consumed byte without error; otherwise frame type
  // and data length are zero.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o ? (region_o != rfd_pkg::REG_NONE &&
                                    error_code_o == rfd_pkg::ERR_NONE)
                                 : (frame_type_o == 16'd0 && data_len_o == 32'd0)))
    else $error("frame end flag inconsistent with result");

endmodule

bind rpc_frame_deframer rfd_checker u_rfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .abort_i      (abort_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .byte_out_o   (byte_out_o),
  .region_o     (region_o),
  .frame_end_o  (frame_end_o),
  .error_code_o (error_code_o),
  .frame_type_o (frame_type_o),
  .data_len_o   (data_len_o)
);

`default_nettype wire

/* test/frame_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the deframer and the register write port. Every
// byte beat taken in is decoded here into the result beat it must produce,
// and every result beat handed out is compared with the oldest decoded one.
module frame_checker (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,

  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        byte_in_i,
  input  logic              abort_i,

  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        byte_out_i,
  input  logic [1:0]        region_i,
  input  logic              frame_end_i,
  input  logic [1:0]        error_code_i,
  input  logic [15:0]       frame_type_i,
  input  logic [15:0]       control_len_i,
  input  logic [31:0]       data_len_i,
  input  logic [7:0]        msg_offset_i,
  input  logic [7:0]        flags_i,

  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o
);

  typedef struct packed {
    logic [7:0]       byte_val;
    rfd_pkg::region_e region;
    logic             frame_end;
    rfd_pkg::err_e    err;
    logic [15:0]      frame_type;
    logic [15:0]      ctl_len;
    logic [31:0]      dat_len;
    logic [7:0]       offset;
    logic [7:0]       flags;
  } beat_t;

  beat_t           decoded_q [$];
  beat_t           want;
  beat_t           got;
  rfd_pkg::phase_e ph;
  rfd_pkg::err_e   held_err;
  logic [31:0]     taken;
  logic [7:0]      hdr [rfd_pkg::HdrBytes];
  logic [15:0]     magic_cfg;
  logic [31:0]     max_len_cfg;
  int unsigned     mismatch_cnt;

  function automatic logic [15:0] hdr_ctl_len();
    return {hdr[rfd_pkg::CtlLenAt + 1], hdr[rfd_pkg::CtlLenAt]};
  endfunction

  function automatic logic [31:0] hdr_data_len();
    return {hdr[rfd_pkg::DataLenAt + 3], hdr[rfd_pkg::DataLenAt + 2],
            hdr[rfd_pkg::DataLenAt + 1], hdr[rfd_pkg::DataLenAt]};
  endfunction

  function automatic string beat_str(beat_t b);
    return $sformatf({"byte %02h region %0d end %0b err %0d type %04h ctl %04h",
                      " dlen %08h off %02h flags %02h"},
                     b.byte_val, b.region, b.frame_end, b.err, b.frame_type, b.ctl_len,
                     b.dat_len, b.offset, b.flags);
  endfunction

  // Advances the decoder by one byte and returns the beat it must produce.
  task automatic decode_byte(input logic [7:0] b, input logic ab, output beat_t r);
    logic done;
    done       = 1'b0;
    r          = '0;
    r.byte_val = b;
    if (ab) begin
      held_err = rfd_pkg::ERR_NONE;
      ph       = rfd_pkg::PH_HEADER;
      taken    = '0;
      r.region = rfd_pkg::REG_NONE;
    end else if (held_err != rfd_pkg::ERR_NONE) begin
      r.region = rfd_pkg::REG_NONE;
    end else begin
      case (ph)
        rfd_pkg::PH_CONTROL: begin
          r.region = rfd_pkg::REG_CONTROL;
          taken++;
          if (taken >= 32'(hdr_ctl_len())) begin
            if (hdr_data_len() == '0) begin
              done = 1'b1;
            end else begin
              ph    = rfd_pkg::PH_DATA;
              taken = '0;
            end
          end
        end
        rfd_pkg::PH_DATA: begin
          r.region = rfd_pkg::REG_DATA;
          taken++;
          if (taken >= hdr_data_len()) done = 1'b1;
        end
        default: begin
          ph       = rfd_pkg::PH_HEADER;
          r.region = rfd_pkg::REG_HEADER;
          if (taken < rfd_pkg::HdrBytes) hdr[taken] = b;
          taken++;
          if (taken >= rfd_pkg::HdrBytes) begin
            taken = '0;
            if ({hdr[rfd_pkg::MagicAt + 1], hdr[rfd_pkg::MagicAt]} != magic_cfg)
              held_err = rfd_pkg::ERR_MAGIC;
            else if (hdr[rfd_pkg::OffsetAt] < rfd_pkg::HdrBytes)
              held_err = rfd_pkg::ERR_OFFSET;
            else if (hdr_data_len() > max_len_cfg) held_err = rfd_pkg::ERR_DLEN;
            else if (hdr_ctl_len() != '0) ph = rfd_pkg::PH_CONTROL;
            else if (hdr_data_len() != '0) ph = rfd_pkg::PH_DATA;
            else done = 1'b1;
          end
        end
      endcase
    end
    r.err = held_err;
    if (done) begin
      r.frame_end  = 1'b1;
      r.frame_type = {hdr[rfd_pkg::TypeAt + 1], hdr[rfd_pkg::TypeAt]};
      r.ctl_len    = hdr_ctl_len();
      r.dat_len    = hdr_data_len();
      r.offset     = hdr[rfd_pkg::OffsetAt];
      r.flags      = hdr[rfd_pkg::FlagsAt];
      ph           = rfd_pkg::PH_HEADER;
      taken        = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_q.delete();
      ph            = rfd_pkg::PH_HEADER;
      held_err      = rfd_pkg::ERR_NONE;
      taken         = '0;
      magic_cfg     = '0;
      max_len_cfg   = '1;
      mismatch_cnt  = 0;
      foreach (hdr[k]) hdr[k] = '0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rfd_pkg::CfgMagic:      magic_cfg   = cfg_wdata_i[15:0];
          rfd_pkg::CfgMaxDataLen: max_len_cfg = cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got.byte_val   = byte_out_i;
        got.region     = rfd_pkg::region_e'(region_i);
        got.frame_end  = frame_end_i;
        got.err        = rfd_pkg::err_e'(error_code_i);
        got.frame_type = frame_type_i;
        got.ctl_len    = control_len_i;
        got.dat_len    = data_len_i;
        got.offset     = msg_offset_i;
        got.flags      = flags_i;
        if (decoded_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unpredicted result beat: %s", beat_str(got));
        end else begin
          want = decoded_q.pop_front();
          if (got.byte_val !== want.byte_val || got.region !== want.region ||
              got.frame_end !== want.frame_end || got.err !== want.err ||
              got.frame_type !== want.frame_type || got.ctl_len !== want.ctl_len ||
              got.dat_len !== want.dat_len || got.offset !== want.offset ||
              got.flags !== want.flags) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("result mismatch, expected %s", beat_str(want));
              $display("                 actual   %s", beat_str(got));
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        decode_byte(byte_in_i, abort_i, want);
        decoded_q.push_back(want);
      end

      outstanding_o <= decoded_q.size();
      mismatches_o  <= mismatch_cnt;
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

// Top of the deframer test. It only generates traffic and decides the
// verdict; all prediction and comparison lives in frame_checker, which sits
// beside the block and watches the same wires.
//
// Traffic is a byte stream, one byte per input beat. After a short directed
// opening (an empty frame with extreme header fields, then a header that
// fails the offset check followed by an abort), the stream is mostly
// well-formed frames with random content, mixed with headers that fail each
// of the three checks, frames cut short by an abort, and raw noise. Every
// error or cut is closed by an abort beat so the decoder is back in sync.
// The run steps through several register settings; registers are only
// written once every predicted result beat has come back.
module testbench;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = rfd_pkg::CfgMagic;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  byte_in_i   = '0;
  logic        abort_i     = 1'b0;
  logic        out_ready_i = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  byte_out_o;
  logic [1:0]  region_o;
  logic        frame_end_o;
  logic [1:0]  error_code_o;
  logic [15:0] frame_type_o;
  logic [15:0] control_len_o;
  logic [31:0] data_len_o;
  logic [7:0]  msg_offset_o;
  logic [7:0]  flags_o;

  int unsigned mismatches;
  int unsigned outstanding;

  // Stimulus bookkeeping, used for the pacing of the run and the summary.
  int unsigned beats_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned bad_headers  = 0;
  int unsigned cut_frames   = 0;
  int unsigned abort_beats  = 0;
  int unsigned settings_run = 1;
  bit          fast_mode    = 1'b0;
  logic [15:0] cur_magic    = '0;
  logic [31:0] cur_max      = '1;

  rpc_frame_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .abort_i       (abort_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_o    (byte_out_o),
    .region_o      (region_o),
    .frame_end_o   (frame_end_o),
    .error_code_o  (error_code_o),
    .frame_type_o  (frame_type_o),
    .control_len_o (control_len_o),
    .data_len_o    (data_len_o),
    .msg_offset_o  (msg_offset_o),
    .flags_o       (flags_o)
  );

  frame_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .abort_i       (abort_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_i    (byte_out_o),
    .region_i      (region_o),
    .frame_end_i   (frame_end_o),
    .error_code_i  (error_code_o),
    .frame_type_i  (frame_type_o),
    .control_len_i (control_len_o),
    .data_len_i    (data_len_o),
    .msg_offset_i  (msg_offset_o),
    .flags_i       (flags_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Offers one byte beat after a random gap and returns at the edge that
  // takes it. Valid is only lowered when there is a gap, so back-to-back
  // beats keep it high without a second assignment in the same step.
  task automatic send_beat(input logic [7:0] b, input logic ab);
    int unsigned gap;
    gap = fast_mode ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    abort_i    <= ab;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    if (ab) abort_beats++;
  endtask

  // Sends a 12-byte little-endian header and then up to body_cap of the
  // control and data bytes it announces. A cap below the announced length
  // leaves the frame open, which callers use for cut frames and for the few
  // bytes that follow a failing header.
  task automatic send_frame(input logic [15:0] mag, input logic [15:0] typ,
                            input logic [15:0] ctl, input logic [31:0] dlen,
                            input logic [7:0] off, input logic [7:0] flg,
                            input logic [31:0] body_cap);
    logic [95:0]     hv;
    longint unsigned body;
    hv   = {flg, off, dlen, ctl, typ, mag};
    body = 64'(ctl) + 64'(dlen);
    if (body > 64'(body_cap)) body = 64'(body_cap);
    for (int i = 0; i < rfd_pkg::HdrBytes; i++) send_beat(hv[8*i +: 8], 1'b0);
    repeat (body) send_beat(8'($urandom), 1'b0);
    frames_sent++;
  endtask

  // Stops offering and waits until every predicted result beat has left.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Writes the magic register, then the maximum data length register.
  task automatic set_regs(input logic [15:0] mag, input logic [31:0] max_len);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rfd_pkg::CfgMagic;
    cfg_wdata_i <= 32'(mag);
    @(posedge clk_i);
    cfg_idx_i   <= rfd_pkg::CfgMaxDataLen;
    cfg_wdata_i <= max_len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_run++;
  endtask

  // Result side. Each beat gets its own random stall, with calm stretches
  // of no stalls at all. Once, early in the random traffic, the receiver
  // holds off so that the output register fills and the block has to push
  // back on the sender.
  initial begin
    int unsigned stall;
    int unsigned results_taken;
    bit          calm;
    results_taken = 0;
    calm          = 1'b0;
    wait (rst_ni);
    forever begin
      if (results_taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (results_taken == 150) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        stall = calm ? 0 : $urandom_range(0, 8);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      results_taken++;
    end
  end

  // Main stimulus and verdict.
  initial begin
    int unsigned target;
    int unsigned kind;
    int unsigned n;
    logic [15:0] typ;
    logic [15:0] ctl;
    logic [15:0] mag;
    logic [31:0] dlen;
    logic [31:0] span;
    logic [7:0]  off;
    logic [7:0]  flg;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed opening under the reset register values. First an empty
    // frame that ends on its last header byte, with all-ones type, offset
    // and flags. Then a header whose offset is one short of the header
    // size, which must latch the offset error, cleared by an abort beat.
    send_frame(16'h0000, 16'hFFFF, 16'h0000, 32'h0000_0000, 8'hFF, 8'hFF, '1);
    send_frame(16'h0000, 16'h0000, 16'h0001, 32'hFFFF_FFFF,
               8'(rfd_pkg::HdrBytes - 1), 8'h00, '0);
    bad_headers++;
    send_beat(8'hFF, 1'b1);

    target = beats_sent;
    for (int s = 0; s < 6; s++) begin
      // The first setting keeps the reset values. Later ones are written
      // only after the sender has paused and every result beat is back.
      if (s != 0) begin
        drain();
        case (s)
          1: begin
            cur_magic = 16'hFFFF;
            cur_max   = 32'h0000_0000;
          end
          2: begin
            cur_magic = 16'($urandom);
            cur_max   = 32'($urandom_range(1, 64));
          end
          3: begin
            cur_magic = 16'($urandom);
            cur_max   = 32'hFFFF_FFFF;
          end
          4: begin
            cur_magic = 16'($urandom);
            cur_max   = 32'h8000_0000;
          end
          default: begin
            cur_magic = 16'h0000;
            cur_max   = 32'($urandom_range(rfd_pkg::HdrBytes, 40));
          end
        endcase
        set_regs(cur_magic, cur_max);
      end

      target += 175;
      while (beats_sent < target) begin
        kind      = $urandom_range(0, 99);
        fast_mode = ($urandom_range(0, 3) == 0);
        typ       = 16'($urandom);
        flg       = 8'($urandom);
        off       = 8'($urandom_range(rfd_pkg::HdrBytes, 255));
        ctl       = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        dlen      = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
        // Now and then a long data section, and sometimes one right at
        // the configured maximum when that maximum is small.
        if ($urandom_range(0, 39) == 0) dlen = 32'($urandom_range(100, 200));
        if (cur_max <= 64 && $urandom_range(0, 9) == 0) dlen = cur_max;
        if (dlen > cur_max) dlen = cur_max;
        span = 32'hFFFF_FFFF - cur_max;

        if (kind < 70 || (kind >= 84 && kind < 92 && span == 0)) begin
          // Well-formed frame, possibly with empty sections.
          send_frame(cur_magic, typ, ctl, dlen, off, flg, '1);
        end else if (kind < 92) begin
          // Header that fails one check. A few bytes follow while the
          // error is held, then an abort clears it.
          ctl = 16'($urandom);
          mag = cur_magic;
          if (kind < 77) begin
            mag  = cur_magic ^ 16'($urandom_range(1, 65535));
            dlen = $urandom;
            off  = 8'($urandom);
          end else if (kind < 84) begin
            off  = 8'($urandom_range(0, rfd_pkg::HdrBytes - 1));
            dlen = $urandom;
          end else begin
            dlen = ($urandom_range(0, 3) == 0) ? cur_max + 1 : cur_max + 1 + ($urandom % span);
          end
          send_frame(mag, typ, ctl, dlen, off, flg, 32'($urandom_range(0, 3)));
          send_beat(8'($urandom), 1'b1);
          bad_headers++;
        end else if (kind < 96) begin
          // Good header, body cut somewhere by an abort.
          send_frame(cur_magic, typ, ctl, dlen, off, flg,
                     32'($urandom_range(0, 32'(ctl) + dlen)));
          send_beat(8'($urandom), 1'b1);
          cut_frames++;
        end else begin
          // Raw noise, usually a partial or failing header, then an abort.
          n = $urandom_range(1, 14);
          repeat (n) send_beat(8'($urandom), 1'b0);
          send_beat(8'($urandom), 1'b1);
        end
      end
    end

    drain();
    repeat (5) @(posedge clk_i);

    $display("covered %0d byte beats in %0d frames under %0d register settings",
             beats_sent, frames_sent, settings_run);
    $display("including %0d failing headers, %0d cut frames and %0d abort beats",
             bad_headers, cut_frames, abort_beats);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout with %0d result beats still owed", outstanding);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
sv/rfd_pkg.sv
sv/rpc_frame_deframer.sv
sv/rfd_checker.sv
test/frame_checker.sv
test/testbench.sv
